// File: rtl/varint_length_prefixed_deframer_unit_defines.svh
// ----------------------------------------------------------------------------
// Varint deframer assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VARINT_LENGTH_PREFIXED_DEFRAMER_UNIT_DEFINES_SVH
`define VARINT_LENGTH_PREFIXED_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define VLPD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VLPD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/vlpd_pkg.sv
// ----------------------------------------------------------------------------
// vlpd_pkg
// Types and codes shared by the compact-size varint deframer.
// ----------------------------------------------------------------------------
package vlpd_pkg;

    localparam logic [1:0] PH_PREFIX  = 2'd0;
    localparam logic [1:0] PH_WIDE    = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_HALT    = 2'd3;

    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_OVER_INT64 = 3'd1;
    localparam logic [2:0] ERR_OVER_LIMIT = 3'd2;
    localparam logic [2:0] ERR_SHORT_BUF  = 3'd3;
    localparam logic [2:0] ERR_PAST_END   = 3'd4;

    localparam logic [1:0] REG_MODE        = 2'd0;
    localparam logic [1:0] REG_MAX_LENGTH  = 2'd1;
    localparam logic [1:0] REG_BUFFER_SIZE = 2'd2;

    localparam logic [7:0] PREFIX_W2 = 8'hFD;
    localparam logic [7:0] PREFIX_W4 = 8'hFE;
    localparam logic [7:0] PREFIX_W8 = 8'hFF;

    localparam logic [62:0] MAX_LENGTH_RST = {63{1'b1}};

    typedef struct packed {
        logic        mode;
        logic [62:0] max_length;
        logic [31:0] buffer_size;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [62:0] value;
        logic        last;
        logic [2:0]  code;
    } res_t;

endpackage

// File: rtl/vlpd_cfg.sv
// ----------------------------------------------------------------------------
// vlpd_cfg
// APB register file: mode, max_length, buffer_size.
// ----------------------------------------------------------------------------
module vlpd_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    output vlpd_pkg::cfg_t cfg
);
    import vlpd_pkg::*;

    logic        mode_reg;
    logic [62:0] max_length_reg;
    logic [31:0] buffer_size_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b1;
            max_length_reg  <= MAX_LENGTH_RST;
            buffer_size_reg <= 32'd0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MODE:        mode_reg        <= pwdata[0];
                REG_MAX_LENGTH:  max_length_reg  <= pwdata[62:0];
                REG_BUFFER_SIZE: buffer_size_reg <= pwdata[31:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MODE:        prdata = {63'd0, mode_reg};
            REG_MAX_LENGTH:  prdata = {1'b0, max_length_reg};
            REG_BUFFER_SIZE: prdata = {32'd0, buffer_size_reg};
            default:         prdata = 64'd0;
        endcase
    end

    assign cfg.mode        = mode_reg;
    assign cfg.max_length  = max_length_reg;
    assign cfg.buffer_size = buffer_size_reg;

endmodule

// File: rtl/vlpd_parse.sv
// ----------------------------------------------------------------------------
// vlpd_parse
// Prefix/payload parser state and the per-byte decode logic.
// ----------------------------------------------------------------------------
module vlpd_parse #(
    parameter int MAX_ARRAY = 16777216
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  logic [7:0]     data_byte,
    input  logic           new_buffer,
    input  vlpd_pkg::cfg_t cfg,
    output vlpd_pkg::res_t res
);
    import vlpd_pkg::*;

    localparam int          PL_W      = $clog2(MAX_ARRAY + 1);
    localparam logic [62:0] MAX_ARR_V = 63'(MAX_ARRAY);

    logic [1:0]      phase_reg, phase_next;
    logic [3:0]      pbl_reg, pbl_next;
    logic [1:0]      pw_reg, pw_next;
    logic [63:0]     acc_reg, acc_next;
    logic [PL_W-1:0] pl_reg, pl_next;
    logic [31:0]     rp_reg, rp_next;

    always_comb
    begin
        logic [1:0]      ph_e;
        logic [3:0]      pbl_e;
        logic [1:0]      pw_e;
        logic [63:0]     acc_e;
        logic [PL_W-1:0] pl_e;
        logic [31:0]     rp_e;
        logic [31:0]     bl;
        logic [1:0]      pw_new;
        logic [3:0]      need;
        logic [3:0]      total;
        logic [2:0]      idx;
        logic [63:0]     acc_ins;
        logic            fin_go;
        logic [63:0]     fin_v;
        logic            fin_w8;
        logic            fail_go;
        logic [2:0]      fail_code;

        ph_e  = new_buffer ? PH_PREFIX : phase_reg;
        pbl_e = new_buffer ? 4'd0 : pbl_reg;
        pw_e  = new_buffer ? 2'd0 : pw_reg;
        acc_e = new_buffer ? 64'd0 : acc_reg;
        pl_e  = new_buffer ? '0 : pl_reg;
        rp_e  = new_buffer ? 32'd0 : rp_reg;

        // bytes left after this one: size - pos - 1
        bl      = cfg.buffer_size + ~rp_e;
        pw_new  = (data_byte == PREFIX_W2) ? 2'd1 : (data_byte == PREFIX_W4) ? 2'd2 : 2'd3;
        need    = 4'd1 << pw_new;
        total   = 4'd1 << pw_e;
        idx     = 3'(total - pbl_e);
        acc_ins = acc_e | ({56'd0, data_byte} << {idx, 3'b000});

        phase_next = ph_e;
        pbl_next   = pbl_e;
        pw_next    = pw_e;
        acc_next   = acc_e;
        pl_next    = pl_e;
        rp_next    = rp_e;
        fin_go     = 1'b0;
        fin_v      = 64'd0;
        fin_w8     = 1'b0;
        fail_go    = 1'b0;
        fail_code  = ERR_NONE;
        res        = '0;

        if (ph_e != PH_HALT)
        begin
            if (rp_e >= cfg.buffer_size)
            begin
                fail_go   = 1'b1;
                fail_code = ERR_PAST_END;
            end
            else
            begin
                rp_next = rp_e + 32'd1;
                case (ph_e)
                    PH_PREFIX:
                    begin
                        if (data_byte < PREFIX_W2)
                        begin
                            fin_go = 1'b1;
                            fin_v  = {56'd0, data_byte};
                        end
                        else if ({28'd0, need} > bl)
                        begin
                            fail_go   = 1'b1;
                            fail_code = ERR_PAST_END;
                        end
                        else
                        begin
                            pw_next    = pw_new;
                            pbl_next   = need;
                            acc_next   = 64'd0;
                            phase_next = PH_WIDE;
                        end
                    end
                    PH_WIDE:
                    begin
                        acc_next = acc_ins;
                        pbl_next = pbl_e - 4'd1;
                        if (pbl_e == 4'd1)
                        begin
                            fin_go = 1'b1;
                            fin_v  = acc_ins;
                            fin_w8 = (pw_e == 2'd3);
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        pl_next   = pl_e - 1'b1;
                        res.valid = 1'b1;
                        res.kind  = KIND_BYTE;
                        res.value = {55'd0, data_byte};
                        res.last  = (pl_e == PL_W'(1));
                        if (pl_e == PL_W'(1))
                            phase_next = PH_PREFIX;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (fin_go)
        begin
            if (fin_w8 && fin_v[63])
            begin
                fail_go   = 1'b1;
                fail_code = ERR_OVER_INT64;
            end
            else if (fin_v[62:0] > cfg.max_length)
            begin
                fail_go   = 1'b1;
                fail_code = ERR_OVER_LIMIT;
            end
            else
            begin
                pbl_next  = 4'd0;
                pw_next   = 2'd0;
                acc_next  = 64'd0;
                res.valid = 1'b1;
                res.kind  = KIND_VALUE;
                res.value = fin_v[62:0];
                res.last  = 1'b1;
                if (!cfg.mode)
                    phase_next = PH_PREFIX;
                else if (fin_v[62:0] > MAX_ARR_V)
                begin
                    fail_go   = 1'b1;
                    fail_code = ERR_OVER_LIMIT;
                end
                else if (fin_v[62:0] > {31'd0, bl})
                begin
                    fail_go   = 1'b1;
                    fail_code = ERR_SHORT_BUF;
                end
                else if (fin_v[62:0] == 63'd0)
                    phase_next = PH_PREFIX;
                else
                begin
                    pl_next    = fin_v[PL_W-1:0];
                    phase_next = PH_PAYLOAD;
                    res.last   = 1'b0;
                end
            end
        end

        if (fail_go)
        begin
            phase_next = PH_HALT;
            pbl_next   = 4'd0;
            pw_next    = 2'd0;
            acc_next   = 64'd0;
            pl_next    = '0;
            res.valid  = 1'b1;
            res.kind   = KIND_ERROR;
            res.value  = 63'd0;
            res.last   = 1'b1;
            res.code   = fail_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            pbl_reg   <= 4'd0;
            pw_reg    <= 2'd0;
            acc_reg   <= 64'd0;
            pl_reg    <= '0;
            rp_reg    <= 32'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            pbl_reg   <= pbl_next;
            pw_reg    <= pw_next;
            acc_reg   <= acc_next;
            pl_reg    <= pl_next;
            rp_reg    <= rp_next;
        end
    end

endmodule

// File: rtl/varint_length_prefixed_deframer_unit.sv
// ----------------------------------------------------------------------------
// varint_length_prefixed_deframer_unit
// Compact-size length prefix deframer: decodes 1/3/5/9-byte prefixes and
// forwards payload bytes, with range and buffer bound checks.
//
//   channel  | dir | handshake         | payload
//   s_*      | in  | s_tvalid/s_tready | tdata: data_byte; tuser: new_buffer
//   m_*      | out | m_tvalid/m_tready | tdata: value, error_code; tuser: kind
//   APB      | in  | psel/penable      | mode, max_length, buffer_size
//
// One beat per cycle sustained while m_tready is high; the path runs from the input
// register to the result register through the parser's decode logic.
// Parser state updates in the same cycle a byte leaves the input register.
// Output stall holds the result; input keeps filling until both stages hold.
// Reset clears all control and parser state; config registers take reset values, data registers are not reset.
// ----------------------------------------------------------------------------
`include "varint_length_prefixed_deframer_unit_defines.svh"

module varint_length_prefixed_deframer_unit #(
    parameter int MAX_ARRAY = 16777216
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] new_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [62:0] value, [65:63] error_code, rest zero
    output logic [1:0]  m_tuser,    // [1:0] item_kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import vlpd_pkg::*;

    cfg_t        cfg;
    res_t        res;
    logic        fire;
    logic        in_vld_reg, in_vld_next;
    logic [7:0]  in_byte_reg;
    logic        in_nb_reg;
    logic        out_vld_reg, out_vld_next;
    logic [1:0]  out_kind_reg;
    logic [62:0] out_value_reg;
    logic        out_last_reg;
    logic [2:0]  out_code_reg;

    vlpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vlpd_parse #(
        .MAX_ARRAY (MAX_ARRAY)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .data_byte  (in_byte_reg),
        .new_buffer (in_nb_reg),
        .cfg        (cfg),
        .res        (res)
    );

    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready)
            in_vld_next = 1'b1;
        else if (fire)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (fire)
            out_vld_next = res.valid;
        else if (m_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_nb_reg   <= s_tuser;
        end
        if (fire && res.valid)
        begin
            out_kind_reg  <= res.kind;
            out_value_reg <= res.value;
            out_last_reg  <= res.last;
            out_code_reg  <= res.code;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_code_reg, out_value_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `VLPD_ASSERT_IMP(a_err_form, m_tvalid && (m_tuser == KIND_ERROR),
        m_tlast && (m_tdata[62:0] == 63'd0) && (m_tdata[65:63] != ERR_NONE),
        "error beat malformed")
    `VLPD_ASSERT_IMP(a_code_clear, m_tvalid && (m_tuser != KIND_ERROR),
        m_tdata[65:63] == ERR_NONE, "error code on non-error beat")
    `VLPD_ASSERT_IMP(a_byte_range, m_tvalid && (m_tuser == KIND_BYTE),
        m_tdata[62:8] == 55'd0, "payload beat wider than a byte")
    `VLPD_ASSERT_NXT(a_in_capture, s_tvalid && s_tready,
        in_vld_reg, "accepted beat not held in input register")

endmodule
